FILE: sv/apf_pkg.sv
// Shared types and constants for the average pooling forward unit.
// No dependencies.
package apf_pkg;

   localparam int CfgWidthBits = 9;
   localparam int CfgWinBits   = 4;

   typedef enum logic [2:0] {
      REG_IN_WIDTH  = 3'd0,
      REG_IN_HEIGHT = 3'd1,
      REG_CHANNELS  = 3'd2,
      REG_WIN_COLS  = 3'd3,
      REG_WIN_ROWS  = 3'd4,
      REG_STEP_COLS = 3'd5,
      REG_STEP_ROWS = 3'd6,
      REG_UNUSED    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DRAIN,
      ST_LOAD,
      ST_DIVIDE,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic write_sample;   // store accepted sample
      logic clear_sum;      // start a window
      logic read_row;       // issue a read of one window element
      logic add_row;        // fold returned sample into the sum
      logic next_row;       // advance the read column and row indices
      logic div_start;      // load the divider
      logic div_step;       // one quotient bit
      logic advance_pos;    // step the stream position
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic hit;            // this sample closes a window
      logic rows_done;      // all window rows issued
      logic div_done;       // quotient ready
   } status_type;

endpackage

FILE: sv/apf_ctrl.sv
// Controller state machine of the average pooling forward unit.
// Depends on apf_pkg.
module apf_ctrl
   import apf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.write_sample = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.clear_sum = 1'b1;
            if (status.hit) begin
               state_in = ST_READ;
            end else begin
               cmd.advance_pos = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // read data lands in the next cycle and is summed there
            cmd.read_row = 1'b1;
            cmd.next_row = 1'b1;
            if (status.rows_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.add_row = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // the sum is complete now; hand it to the divider
            cmd.div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance_pos = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // the previously read sample is added while the next is issued
      if (state_ff == ST_READ) begin
         cmd.add_row = 1'b1;
      end
   end

endmodule

FILE: sv/apf_datapath.sv
// Datapath of the average pooling forward unit: line store, position
// counters, window row sum and a restoring divider. Depends on apf_pkg.
module apf_datapath
   import apf_pkg::*;
#(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_WIN     = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [8:0]             csr_data,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [SAMPLE_BITS-1:0] rsp_average,
   output logic [7:0]             rsp_out_col,
   output logic [7:0]             rsp_out_row,
   output logic [7:0]             rsp_out_channel,
   output logic                   rsp_last
);

   localparam int ColBits  = $clog2(MAX_WIDTH);
   localparam int PosBits  = $clog2(MAX_WIDTH + 1) + 1;
   localparam int WinBits  = $clog2(MAX_WIN + 1);
   localparam int SlotBits = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
   localparam int AreaBits = 2 * WinBits;
   localparam int SumBits  = SAMPLE_BITS + AreaBits + 1;
   localparam int MagBits  = SumBits;
   localparam int DivCntBits = $clog2(MagBits + 1);
   localparam int Depth    = MAX_WIN * MAX_WIDTH;
   localparam int AddrBits = $clog2(Depth);

   // configuration registers, raw
   logic [8:0] in_width_ff, in_height_ff, channels_ff;
   logic [3:0] win_cols_ff, win_rows_ff, step_cols_ff, step_rows_ff;

   // a write to a listed register restarts the stream
   logic restart;
   assign restart = csr_write && (reg_index_type'(csr_index) != REG_UNUSED);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= 9'd8;
         in_height_ff <= 9'd8;
         channels_ff  <= 9'd1;
         win_cols_ff  <= 4'd2;
         win_rows_ff  <= 4'd2;
         step_cols_ff <= 4'd2;
         step_rows_ff <= 4'd2;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_IN_WIDTH:  in_width_ff  <= csr_data;
            REG_IN_HEIGHT: in_height_ff <= csr_data;
            REG_CHANNELS:  channels_ff  <= csr_data;
            REG_WIN_COLS:  win_cols_ff  <= csr_data[3:0];
            REG_WIN_ROWS:  win_rows_ff  <= csr_data[3:0];
            REG_STEP_COLS: step_cols_ff <= csr_data[3:0];
            REG_STEP_ROWS: step_rows_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   function automatic logic [PosBits-1:0] clamp_size(input logic [8:0] v);
      logic [PosBits-1:0] r;
      if (v == '0) r = PosBits'(1);
      else if (PosBits'(v) > PosBits'(MAX_WIDTH)) r = PosBits'(MAX_WIDTH);
      else r = PosBits'(v);
      return r;
   endfunction

   function automatic logic [WinBits-1:0] clamp_win(input logic [3:0] v);
      logic [WinBits-1:0] r;
      if (v == '0) r = WinBits'(1);
      else if (32'(v) > MAX_WIN) r = WinBits'(MAX_WIN);
      else r = WinBits'(v);
      return r;
   endfunction

   logic [PosBits-1:0] w, h, nc;
   logic [WinBits-1:0] wc, wr, sc, sr;
   assign w  = clamp_size(in_width_ff);
   assign h  = clamp_size(in_height_ff);
   assign nc = clamp_size(channels_ff);
   assign wc = clamp_win(win_cols_ff);
   assign wr = clamp_win(win_rows_ff);
   assign sc = clamp_win(step_cols_ff);
   assign sr = clamp_win(step_rows_ff);

   // stream position
   logic [PosBits-1:0] col_ff, row_ff, chan_ff;
   logic [PosBits-1:0] col_in, row_in, chan_in;

   always_comb begin
      col_in  = col_ff + PosBits'(1);
      row_in  = row_ff;
      chan_in = chan_ff;
      if (col_in >= w) begin
         col_in = '0;
         row_in = row_ff + PosBits'(1);
         if (row_in >= h) begin
            row_in  = '0;
            chan_in = chan_ff + PosBits'(1);
            if (chan_in >= nc) chan_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else if (cmd.advance_pos) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   // Output index tracking: phase counters avoid dividing by the stride.
   // Column phase counts window starts; it is rebuilt each row.
   logic [WinBits-1:0] cph_ff, rph_ff;   // (pos+1-win) mod stride
   logic [7:0]         ocol_ff, orow_ff;
   logic               cok_ff, rok_ff;   // pos+1 >= win reached
   logic [7:0]         last_oc_ff, last_or_ff;

   logic [PosBits-1:0] col_p1, row_p1;
   assign col_p1 = col_ff + PosBits'(1);
   assign row_p1 = row_ff + PosBits'(1);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         cph_ff <= '0;
         rph_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         cok_ff <= 1'b0;
         rok_ff <= 1'b0;
      end else if (cmd.advance_pos) begin
         // column side: state describes column col_in
         if (col_in == '0) begin
            cok_ff  <= (wc == WinBits'(1));
            cph_ff  <= '0;
            ocol_ff <= '0;
            if (row_in != row_ff) begin
               if (row_in == '0) begin
                  rok_ff  <= (wr == WinBits'(1));
                  rph_ff  <= '0;
                  orow_ff <= '0;
               end else if (rok_ff) begin
                  if (rph_ff + WinBits'(1) == sr) begin
                     rph_ff  <= '0;
                     orow_ff <= orow_ff + 8'd1;
                  end else begin
                     rph_ff <= rph_ff + WinBits'(1);
                  end
               end else if (row_in + PosBits'(1) >= PosBits'(wr)) begin
                  rok_ff <= 1'b1;
               end
            end
         end else if (cok_ff) begin
            if (cph_ff + WinBits'(1) == sc) begin
               cph_ff  <= '0;
               ocol_ff <= ocol_ff + 8'd1;
            end else begin
               cph_ff <= cph_ff + WinBits'(1);
            end
         end else if (col_in + PosBits'(1) >= PosBits'(wc)) begin
            cok_ff <= 1'b1;
         end
      end else if (!cok_ff && col_ff == '0 && row_ff == '0) begin
         // after reset or a write, settle the flags for position zero
         cok_ff <= (wc == WinBits'(1));
         rok_ff <= (wr == WinBits'(1));
      end
   end

   // last output indices: (size - win) / stride, computed by a counter
   // sweep while idle is costly; instead use the running count at the
   // final window. The final window of a row has col+1+stride > w.
   logic col_final, row_final;
   assign col_final = (col_p1 + PosBits'(sc) > w);
   assign row_final = (row_p1 + PosBits'(sr) > h);
   always_ff @(posedge clock) begin
      last_oc_ff <= ocol_ff;
      last_or_ff <= orow_ff;
   end

   // line store
   logic [SAMPLE_BITS-1:0] store_mem [Depth];
   logic [SlotBits-1:0]    slot;
   logic [ColBits-1:0]     col_idx;
   assign slot    = SlotBits'(row_ff % PosBits'(MAX_WIN));
   assign col_idx = col_ff[ColBits-1:0];

   // window row read: MAX_WIN banks are one memory addressed row-major;
   // read one sample per column of the row over a narrow inner counter
   logic [WinBits-1:0]  rcnt_ff;   // row of the window being read
   logic [WinBits-1:0]  ccnt_ff;   // column within the row
   logic [PosBits-1:0]  rrow;
   logic [PosBits-1:0]  rcol;
   logic [AddrBits-1:0] rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                rd_valid_ff;

   assign rrow = row_p1 - PosBits'(wr) + PosBits'(rcnt_ff);
   assign rcol = col_p1 - PosBits'(wc) + PosBits'(ccnt_ff);
   assign rd_addr = AddrBits'((rrow % PosBits'(MAX_WIN)) * PosBits'(MAX_WIDTH))
                  + AddrBits'(rcol[ColBits-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.write_sample) begin
         store_mem[AddrBits'(slot) * AddrBits'(MAX_WIDTH) + AddrBits'(col_idx)]
            <= req_sample;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read_row;
      end
   end

   logic last_cell;
   assign last_cell = (ccnt_ff + WinBits'(1) == wc) && (rcnt_ff + WinBits'(1) == wr);

   always_ff @(posedge clock) begin
      if (cmd.clear_sum) begin
         rcnt_ff <= '0;
         ccnt_ff <= '0;
      end else if (cmd.next_row) begin
         if (ccnt_ff + WinBits'(1) == wc) begin
            ccnt_ff <= '0;
            rcnt_ff <= rcnt_ff + WinBits'(1);
         end else begin
            ccnt_ff <= ccnt_ff + WinBits'(1);
         end
      end
   end

   // sum
   logic signed [SumBits-1:0] sum_ff;
   always_ff @(posedge clock) begin
      if (cmd.clear_sum) begin
         sum_ff <= '0;
      end else if (cmd.add_row && rd_valid_ff) begin
         sum_ff <= sum_ff + SumBits'($signed(rd_data_ff));
      end
   end

   // restoring divider on magnitudes, one bit a cycle
   logic [AreaBits-1:0]   area;
   logic [MagBits-1:0]    quo_ff, rem_ff;
   logic [DivCntBits-1:0] dcnt_ff;
   logic                  neg_ff;
   logic [MagBits:0]      trial;
   assign area  = AreaBits'(wc) * AreaBits'(wr);
   assign trial = {rem_ff, quo_ff[MagBits-1]} - (MagBits+1)'(area);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff  <= sum_ff[SumBits-1];
         quo_ff  <= sum_ff[SumBits-1] ? MagBits'(-sum_ff) : MagBits'(sum_ff);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step && !status.div_done) begin
         if (!trial[MagBits]) begin
            rem_ff <= trial[MagBits-1:0];
            quo_ff <= {quo_ff[MagBits-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[MagBits-2:0], quo_ff[MagBits-1]};
            quo_ff <= {quo_ff[MagBits-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + DivCntBits'(1);
      end
   end

   logic [MagBits-1:0] signed_quo;
   assign signed_quo = neg_ff ? -quo_ff : quo_ff;

   assign status.hit = cok_ff && rok_ff && (cph_ff == '0) && (rph_ff == '0);
   assign status.rows_done = last_cell;
   assign status.div_done  = (dcnt_ff == DivCntBits'(MagBits));

   assign rsp_average     = signed_quo[SAMPLE_BITS-1:0];
   assign rsp_out_col     = ocol_ff;
   assign rsp_out_row     = orow_ff;
   assign rsp_out_channel = chan_ff[7:0];
   assign rsp_last        = (chan_ff + PosBits'(1) == nc) && col_final && row_final
                            && (last_oc_ff == ocol_ff) && (last_or_ff == orow_ff);

endmodule

FILE: sv/avg_pool_forward_unit.sv
// Top level of the average pooling forward unit.
// Depends on apf_pkg, apf_ctrl and apf_datapath.
//
//   channel  ports                          beat
//   req      req_valid/req_ready            one Q8.8 sample, raster order
//   rsp      rsp_valid/rsp_ready            window mean plus coordinates
//   csr      csr_write/csr_index/csr_data   register write, no wait
//
// A sample that closes no window passes through accept, then window check.
// A closing sample passes through accept, check, one line store read per
// window element, a drain and a divider load state, then the divider (one
// quotient bit per step over SAMPLE_BITS + 2*clog2(MAX_WIN+1) + 1 bits,
// plus a done step) and a result state.
// Reset is synchronous; the line store holds no reset value.
// A stalled result holds the block until it is taken; input is ready only
// while idle.
module avg_pool_forward_unit
   import apf_pkg::*;
#(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_WIN     = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [8:0]             csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_average,
   output logic [7:0]             rsp_out_col,
   output logic [7:0]             rsp_out_row,
   output logic [7:0]             rsp_out_channel,
   output logic                   rsp_last
);

   cmd_type    cmd;
   status_type status;

   apf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   apf_datapath #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_WIN     (MAX_WIN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_sample      (req_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_average     (rsp_average),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_channel (rsp_out_channel),
      .rsp_last        (rsp_last)
   );

endmodule
